// ----- rtl/core/rpp_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rpp_pkg: shared definitions for the random pick pool
// Field widths, request and status codes, remainder unit sizing, and the
// command and status bundles between controller and datapath.
// ============================================================================
package rpp_pkg;

    localparam int DEFAULT_DEPTH       = 1024;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Fixed transaction field widths
    localparam int REQ_W    = 2;
    localparam int PUSH_W   = 32;
    localparam int RND_W    = 31;
    localparam int POP_W    = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH  = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_POP   = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_CLEAR = REQ_W'(2);

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(2);

    // Remainder unit: radix-4 restoring, two quotient bits per cycle
    localparam int REM_BITS_PER_CYCLE = 2;
    localparam int REM_DVD_W  = ((RND_W + REM_BITS_PER_CYCLE - 1) / REM_BITS_PER_CYCLE)
                                * REM_BITS_PER_CYCLE;
    localparam int REM_STEPS  = REM_DVD_W / REM_BITS_PER_CYCLE;
    localparam int REM_STEP_W = $clog2(REM_STEPS);

    typedef struct packed {
        logic latch_req;    // capture the accepted request
        logic do_push;      // append value at the end, count up
        logic do_clear;     // count to zero
        logic flag_empty;   // mark pop on empty pool
        logic flag_full;    // mark push on full pool
        logic rem_start;    // start slot = random mod count
        logic rd_slot;      // read the chosen slot (else read the last entry)
        logic take_popped;  // capture the chosen slot's value
        logic move_last;    // write last value into the slot, count down
        logic load_out;     // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             empty;
        logic             full;
        logic             rem_done;
        logic             out_free;
    } t_dp_status;

endpackage

// ----- rtl/core/rpp_req_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rpp_req_if: request channel
// Valid/ready channel carrying one pool request per transaction.
// ============================================================================
interface rpp_req_if;
    logic                        valid;
    logic                        ready;
    logic [rpp_pkg::REQ_W-1:0]   req_type;
    logic [rpp_pkg::PUSH_W-1:0]  push_value;
    logic [rpp_pkg::RND_W-1:0]   random_word;

    modport source (output valid, output req_type, output push_value,
                    output random_word, input ready);
    modport sink   (input valid, input req_type, input push_value,
                    input random_word, output ready);
endinterface

// ----- rtl/core/rpp_rsp_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rpp_rsp_if: response channel
// Valid/ready channel carrying one pool result per transaction.
// ============================================================================
interface rpp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rpp_pkg::POP_W-1:0]     popped_value;
    logic [rpp_pkg::COUNT_W-1:0]   entry_count;
    logic [rpp_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output popped_value, output entry_count,
                    output status, input ready);
    modport sink   (input valid, input popped_value, input entry_count,
                    input status, output ready);
endinterface

// ----- rtl/core/rpp_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rpp_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module rpp_ram #(
    parameter int WIDTH = rpp_pkg::DEFAULT_VALUE_WIDTH,
    parameter int DEPTH = rpp_pkg::DEFAULT_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/rpp_rem.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rpp_rem: iterative remainder unit
// Restoring division, two dividend bits per cycle; yields dividend mod divisor.
// ============================================================================
module rpp_rem #(
    parameter int DIV_W = 11,
    parameter int REM_W = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rpp_pkg::RND_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [REM_W-1:0]          o_rem
);
    localparam int DVD_W  = rpp_pkg::REM_DVD_W;
    localparam int STEP_W = rpp_pkg::REM_STEP_W;
    localparam int BPC    = rpp_pkg::REM_BITS_PER_CYCLE;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem;

    logic [DIV_W:0]    trial;
    logic [DIV_W-1:0]  n_rem;
    logic [DVD_W-1:0]  n_dvd;

    // Shift in one dividend bit, subtract the divisor when it fits; twice a cycle.
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        trial = '0;
        for (int k = 0; k < BPC; k++) begin
            trial = {n_rem, n_dvd[DVD_W-1]};
            n_dvd = {n_dvd[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem = DIV_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(rpp_pkg::REM_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= DVD_W'(i_dividend);
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_step == STEP_W'(rpp_pkg::REM_STEPS - 1));
    assign o_rem  = r_rem[REM_W-1:0];
endmodule

// ----- rtl/core/rpp_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rpp_datapath: pool storage, count, remainder unit and result register
// Executes the commands of the controller and reports status back.
// ============================================================================
module rpp_datapath #(
    parameter int DEPTH       = rpp_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = rpp_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rpp_pkg::t_dp_cmd             i_cmd,
    output rpp_pkg::t_dp_status          o_status,
    input  logic [rpp_pkg::REQ_W-1:0]    i_req_type,
    input  logic [rpp_pkg::PUSH_W-1:0]   i_push_value,
    input  logic [rpp_pkg::RND_W-1:0]    i_random_word,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [rpp_pkg::POP_W-1:0]    o_popped_value,
    output logic [rpp_pkg::COUNT_W-1:0]  o_entry_count,
    output logic [rpp_pkg::STATUS_W-1:0] o_status_code
);
    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int PX_W = VALUE_WIDTH + rpp_pkg::PUSH_W;
    localparam int PO_W = VALUE_WIDTH + rpp_pkg::POP_W;
    localparam int CX_W = CW + rpp_pkg::COUNT_W;

    logic [rpp_pkg::REQ_W-1:0]    r_req_type;
    logic [VALUE_WIDTH-1:0]       r_value;
    logic [rpp_pkg::RND_W-1:0]    r_rnd;
    logic [CW-1:0]                r_count;
    logic [VALUE_WIDTH-1:0]       r_popped;
    logic [rpp_pkg::STATUS_W-1:0] r_code;
    logic                         r_out_valid;
    logic [rpp_pkg::POP_W-1:0]    r_out_popped;
    logic [rpp_pkg::COUNT_W-1:0]  r_out_count;
    logic [rpp_pkg::STATUS_W-1:0] r_out_code;

    logic [PX_W-1:0]        push_ext;
    logic [PO_W-1:0]        pop_ext;
    logic [CX_W-1:0]        count_ext;
    logic [CW-1:0]          count_dec;
    logic [AW-1:0]          slot;
    logic                   rem_done;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    assign push_ext  = PX_W'(i_push_value);
    assign pop_ext   = PO_W'(r_popped);
    assign count_ext = CX_W'(r_count);
    assign count_dec = r_count - CW'(1);

    rpp_rem #(
        .DIV_W (CW),
        .REM_W (AW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.rem_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_count),
        .o_done     (rem_done),
        .o_rem      (slot)
    );

    // Push writes at the end; pop moves the last value into the freed slot.
    assign ram_we    = i_cmd.do_push || i_cmd.move_last;
    assign ram_waddr = i_cmd.do_push ? r_count[AW-1:0] : slot;
    assign ram_wdata = i_cmd.do_push ? r_value : ram_rdata;
    assign ram_raddr = i_cmd.rd_slot ? slot : count_dec[AW-1:0];

    rpp_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.move_last) begin
                r_count <= count_dec;
            end else if (i_cmd.do_clear) begin
                r_count <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req_type <= i_req_type;
            r_value    <= push_ext[VALUE_WIDTH-1:0];
            r_rnd      <= i_random_word;
        end
        if (i_cmd.latch_req) begin
            r_popped <= '0;
        end else if (i_cmd.take_popped) begin
            r_popped <= ram_rdata;
        end
        if (i_cmd.latch_req) begin
            r_code <= rpp_pkg::ST_DONE;
        end else if (i_cmd.flag_empty) begin
            r_code <= rpp_pkg::ST_EMPTY;
        end else if (i_cmd.flag_full) begin
            r_code <= rpp_pkg::ST_FULL;
        end
        if (i_cmd.load_out) begin
            r_out_popped <= pop_ext[rpp_pkg::POP_W-1:0];
            r_out_count  <= count_ext[rpp_pkg::COUNT_W-1:0];
            r_out_code   <= r_code;
        end
    end

    assign o_status.req_type = r_req_type;
    assign o_status.empty    = (r_count == '0);
    assign o_status.full     = (r_count == CW'(DEPTH));
    assign o_status.rem_done = rem_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_popped;
    assign o_entry_count  = r_out_count;
    assign o_status_code  = r_out_code;
endmodule

// ----- rtl/core/rpp_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rpp_ctrl: request sequencer
// One-hot state machine that steps the datapath through each request.
// ============================================================================
module rpp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rpp_pkg::t_dp_status i_status,
    output rpp_pkg::t_dp_cmd    o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_DIV     = 7'b0000100,
        S_RD_SLOT = 7'b0001000,
        S_RD_LAST = 7'b0010000,
        S_MOVE    = 7'b0100000,
        S_RESULT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // hold off the request channel while reset is asserted
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.latch_req = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESULT;
                unique case (i_status.req_type)
                    rpp_pkg::REQ_PUSH: begin
                        if (i_status.full) begin
                            o_cmd.flag_full = 1'b1;
                        end else begin
                            o_cmd.do_push = 1'b1;
                        end
                    end
                    rpp_pkg::REQ_POP: begin
                        if (i_status.empty) begin
                            o_cmd.flag_empty = 1'b1;
                        end else begin
                            o_cmd.rem_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    rpp_pkg::REQ_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_DIV: begin
                if (i_status.rem_done) begin
                    n_state = S_RD_SLOT;
                end
            end
            S_RD_SLOT: begin
                o_cmd.rd_slot = 1'b1;
                n_state       = S_RD_LAST;
            end
            S_RD_LAST: begin
                o_cmd.take_popped = 1'b1;
                n_state           = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.move_last = 1'b1;
                n_state         = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- rtl/core/random_pick_pool_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// random_pick_pool_top: pool of values with random removal
// Push appends, pop removes the entry at random_word mod count and fills the
// hole with the last entry, clear empties the pool. One result per request.
// ============================================================================
// One request is taken at a time and every request returns exactly one
// result transaction carrying the count after the request and a status.
// A push, a clear, an unused request code, a pop on an empty pool and a push
// on a full pool go from decode straight to the result state. A successful
// pop waits in the remainder unit, which forms random_word mod count two bits
// per cycle, then reads the chosen slot, reads the last entry and writes that
// entry into the slot through the single read and single write port of the
// entry RAM. The result register decouples the two sides: a new request is
// accepted while the previous result still waits for its sink. The entry RAM
// is not cleared; only slots below the count are ever read, so no clearing
// pass is needed after reset or after a clear request.
module random_pick_pool_top #(
    parameter int DEPTH       = rpp_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = rpp_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpp_req_if.sink   i_req,
    rpp_rsp_if.source o_rsp
);
    rpp_pkg::t_dp_cmd    cmd;
    rpp_pkg::t_dp_status status;

    // Sequence each request: accept, decode, optional pop steps, result.
    rpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold storage, count, remainder unit and the output register.
    rpp_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_req_type     (i_req.req_type),
        .i_push_value   (i_req.push_value),
        .i_random_word  (i_req.random_word),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_popped_value (o_rsp.popped_value),
        .o_entry_count  (o_rsp.entry_count),
        .o_status_code  (o_rsp.status)
    );
endmodule

// ----- tb/sv/tb_random_pick_pool_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_random_pick_pool_top: self-checking bench for the random pick pool
// Drives push, pop, clear and unused requests through the request channel and
// compares every response with a typed row or the cycle-free pool model here.
// A short directed table comes first, followed by random phases that grow,
// shrink, fill and empty the pool under random stalls on both channels.
// ============================================================================
module tb_random_pick_pool_top;

    import rpp_pkg::*;

    localparam int POOL_DEPTH       = DEFAULT_DEPTH;
    localparam int POOL_VALUE_WIDTH = DEFAULT_VALUE_WIDTH;
    localparam logic [PUSH_W-1:0] VALUE_MASK = PUSH_W'((64'h1 << POOL_VALUE_WIDTH) - 1);

    // Request code that the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = REQ_W'(3);

    localparam int RANDOM_ITEMS  = 1600;
    localparam int HOLDOFF_AFTER = 300;   // responses seen before the long hold-off
    localparam int HOLDOFF_LEN   = 250;   // cycles with the response sink blocked
    localparam int IDLE_LIMIT    = 4000;  // cycles without any transaction
    localparam int END_WAIT      = 40;    // settle time after the last response

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [PUSH_W-1:0] value;
        logic [RND_W-1:0]  rnd;
    } pool_req_t;

    typedef struct packed {
        logic [POP_W-1:0]    popped;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } pool_res_t;

    // Directed row: request, flag for a hand-typed response, and that response
    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [PUSH_W-1:0]   value;
        logic [RND_W-1:0]    rnd;
        logic                typed;
        logic [POP_W-1:0]    e_popped;
        logic [COUNT_W-1:0]  e_count;
        logic [STATUS_W-1:0] e_status;
    } pool_row_t;

    typedef enum int {PH_MIXED, PH_GROW, PH_SHRINK, PH_FILL, PH_EMPTY} phase_t;

    localparam int DIRECTED_LEN = 21;
    localparam pool_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // pop, clear and an unused request on an empty pool right after reset
        '{REQ_POP,    32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0000_0000, 11'd0, ST_EMPTY},
        '{REQ_POP,    32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'h0000_0000, 11'd0, ST_EMPTY},
        '{REQ_CLEAR,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'h0000_0000, 11'd0, ST_DONE},
        '{REQ_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'h0000_0000, 11'd0, ST_DONE},
        // push all ones and pop it with the largest random word, then push five
        '{REQ_PUSH,   32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'h0000_0000, 11'd1, ST_DONE},
        '{REQ_POP,    32'h0000_0000, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 11'd0, ST_DONE},
        '{REQ_PUSH,   32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0000_0000, 11'd1, ST_DONE},
        '{REQ_PUSH,   32'hA5A5_A5A5, 31'h2AAA_AAAA, 1'b1, 32'h0000_0000, 11'd2, ST_DONE},
        '{REQ_PUSH,   32'h5A5A_5A5A, 31'h5555_5555, 1'b1, 32'h0000_0000, 11'd3, ST_DONE},
        '{REQ_PUSH,   32'h8000_0000, 31'h4000_0000, 1'b1, 32'h0000_0000, 11'd4, ST_DONE},
        '{REQ_PUSH,   32'h0000_0001, 31'h0000_0001, 1'b1, 32'h0000_0000, 11'd5, ST_DONE},
        // swap-remove from the middle, the head and after an ignored request
        '{REQ_POP,    32'h0000_0000, 31'h7FFF_FFFF, 1'b0, 32'h0000_0000, 11'd0, ST_DONE},
        '{REQ_POP,    32'h0000_0000, 31'h0000_0000, 1'b0, 32'h0000_0000, 11'd0, ST_DONE},
        '{REQ_UNUSED, 32'h1234_5678, 31'h0000_0002, 1'b0, 32'h0000_0000, 11'd0, ST_DONE},
        '{REQ_POP,    32'h0000_0000, 31'h0000_0001, 1'b0, 32'h0000_0000, 11'd0, ST_DONE},
        // clear with entries left, then the stale words must stay unreachable
        '{REQ_CLEAR,  32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0000_0000, 11'd0, ST_DONE},
        '{REQ_POP,    32'h0000_0000, 31'h0001_2345, 1'b1, 32'h0000_0000, 11'd0, ST_EMPTY},
        '{REQ_PUSH,   32'h1234_5678, 31'h0000_0000, 1'b1, 32'h0000_0000, 11'd1, ST_DONE},
        '{REQ_UNUSED, 32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0000_0000, 11'd1, ST_DONE},
        '{REQ_POP,    32'h0000_0000, 31'h7FFF_FFFF, 1'b1, 32'h1234_5678, 11'd0, ST_DONE},
        '{REQ_PUSH,   32'h0000_FFFF, 31'h0000_0000, 1'b0, 32'h0000_0000, 11'd0, ST_DONE}
    };

    logic clk;
    logic rst_n;

    rpp_req_if req_ch ();
    rpp_rsp_if rsp_ch ();

    random_pick_pool_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Pool model: packed store plus fill count, advanced once per accepted request
    logic [PUSH_W-1:0] pool_mem [POOL_DEPTH];
    int unsigned       pool_fill;

    pool_res_t pending_results [$];

    int  mismatch_count;
    int  results_seen;
    int  random_issued;
    int  fill_runs;
    bit  sender_burst;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------------

    // Apply one request to the model and return the response it must produce.
    function automatic pool_res_t pool_apply(input pool_req_t r);
        pool_res_t   res;
        int unsigned slot;
        res = '0;
        res.status = ST_DONE;
        case (r.kind)
            REQ_PUSH: begin
                if (pool_fill >= POOL_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pool_mem[pool_fill] = r.value & VALUE_MASK;
                    pool_fill++;
                end
            end
            REQ_POP: begin
                if (pool_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // swap-remove: the last entry moves into the freed slot
                    slot       = r.rnd % pool_fill;
                    res.popped = pool_mem[slot];
                    pool_fill--;
                    pool_mem[slot] = pool_mem[pool_fill];
                end
            end
            REQ_CLEAR: begin
                pool_fill = 0;
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(pool_fill);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------------

    // Mostly no gap, some short ones, a few long ones; none in a burst phase.
    function automatic int pick_sender_gap();
        int unsigned pct;
        pct = $urandom_range(0, 99);
        if (sender_burst || pct < 60) return 0;
        if (pct < 90)                 return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_sink_stall();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [PUSH_W-1:0] pick_push_value();
        int unsigned pct;
        pct = $urandom_range(0, 15);
        if (pct == 0) return '0;
        if (pct == 1) return '1;
        return PUSH_W'($urandom());
    endfunction

    // Slot choice leans on small words, zero and the top of the range too.
    function automatic logic [RND_W-1:0] pick_random_word();
        int unsigned pct;
        pct = $urandom_range(0, 7);
        if (pct == 0) return '0;
        if (pct == 1) return '1;
        if (pct < 4)  return RND_W'($urandom_range(0, 2047));
        return RND_W'($urandom());
    endfunction

    function automatic logic [REQ_W-1:0] pick_kind(input phase_t ph);
        int unsigned pct;
        int unsigned push_cut;
        pct = $urandom_range(0, 99);
        case (ph)
            PH_GROW:   push_cut = 75;
            PH_SHRINK: push_cut = 20;
            default:   push_cut = 45;
        endcase
        if (pct < push_cut) return REQ_PUSH;
        if (pct < 95)       return REQ_POP;
        if (pct < 97)       return REQ_CLEAR;
        return REQ_UNUSED;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request from a falling edge, record its expected response at
    // the accepting edge, then idle for a random gap. Return on a falling edge.
    task automatic send_request(input pool_req_t r, input bit use_typed,
                                input pool_res_t typed);
        pool_res_t res;
        int        gap;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.kind;
        req_ch.push_value  <= r.value;
        req_ch.random_word <= r.rnd;
        do @(posedge clk); while (!req_ch.ready);
        res = pool_apply(r);
        pending_results.push_back(use_typed ? typed : res);
        gap = pick_sender_gap();
        @(negedge clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold the request side quiet until every outstanding response is back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    task automatic run_phase(input phase_t ph, input int len);
        pool_req_t r;
        pool_res_t unused_res;
        int        n;
        int        extra;
        bit        done;
        n          = 0;
        extra      = 0;
        done       = 1'b0;
        unused_res = '0;
        sender_burst = ($urandom_range(0, 3) == 0);
        while (!done) begin
            case (ph)
                PH_FILL: begin
                    // push until full, then a few pushes that must bounce
                    done = (pool_fill >= POOL_DEPTH) && (extra >= 3);
                    if (pool_fill >= POOL_DEPTH) extra++;
                    r.kind = REQ_PUSH;
                end
                PH_EMPTY: begin
                    // pop until empty, then a couple of pops that must bounce
                    done = (pool_fill == 0) && (extra >= 2);
                    if (pool_fill == 0) extra++;
                    r.kind = REQ_POP;
                end
                default: begin
                    done   = (n >= len);
                    r.kind = pick_kind(ph);
                end
            endcase
            // stop any phase once the random budget is spent
            if (random_issued >= RANDOM_ITEMS) done = 1'b1;
            if (!done) begin
                r.value = pick_push_value();
                r.rnd   = pick_random_word();
                send_request(r, 1'b0, unused_res);
                n++;
                if (r.kind != REQ_UNUSED) random_issued++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        pool_req_t r;
        pool_res_t typed;
        phase_t    ph;
        int        phase_idx;
        int unsigned pct;

        clk                = 1'b0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_PUSH;
        req_ch.push_value  = '0;
        req_ch.random_word = '0;
        pool_fill          = 0;
        mismatch_count     = 0;
        random_issued      = 0;
        fill_runs          = 0;
        sender_burst       = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: typed rows check the hand-computed response, the
        // others take the model's response.
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            r.kind         = DIRECTED_ROWS[i].kind;
            r.value        = DIRECTED_ROWS[i].value;
            r.rnd          = DIRECTED_ROWS[i].rnd;
            typed.popped   = DIRECTED_ROWS[i].e_popped;
            typed.count    = DIRECTED_ROWS[i].e_count;
            typed.status   = DIRECTED_ROWS[i].e_status;
            send_request(r, DIRECTED_ROWS[i].typed, typed);
        end
        drain_results();

        // Random phases. The second phase always fills the pool to the top so
        // the full-pool bounce and the largest counts get exercised early.
        phase_idx = 0;
        while (random_issued < RANDOM_ITEMS) begin
            pct = $urandom_range(0, 99);
            if (phase_idx == 1)                  ph = PH_FILL;
            else if (phase_idx == 0 || pct < 30) ph = PH_MIXED;
            else if (pct < 55)                   ph = PH_GROW;
            else if (pct < 80)                   ph = PH_SHRINK;
            else if (pct < 92 || fill_runs >= 2) ph = PH_EMPTY;
            else                                 ph = PH_FILL;
            if (ph == PH_FILL) fill_runs++;
            run_phase(ph, $urandom_range(30, 120));
            // pause for every response after a fill, and now and then anyway
            if (ph == PH_FILL || $urandom_range(0, 3) == 0) drain_results();
            phase_idx++;
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Response side: random ready with short and long stalls, stall-free
    // stretches, and one long hold-off that backs the block up into its
    // request channel while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int mode_left;
        bit sink_burst;
        bit holdoff_done;

        rsp_ch.ready = 1'b0;
        results_seen = 0;
        stall_left   = 0;
        mode_left    = 200;
        sink_burst   = 1'b0;
        holdoff_done = 1'b0;

        forever begin
            @(negedge clk);
            if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
                holdoff_done = 1'b1;
                stall_left   = HOLDOFF_LEN;
            end
            if (!rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!sink_burst && $urandom_range(0, 3) == 0) begin
                stall_left = pick_sink_stall() - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
            mode_left--;
            if (mode_left == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
                mode_left  = $urandom_range(50, 300);
            end

            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                check_response();
            end
        end
    end

    // Compare one response transaction with the oldest expectation.
    task automatic check_response();
        pool_res_t exp;
        results_seen++;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with none expected: popped %h count %0d status %0d",
                     $time, rsp_ch.popped_value, rsp_ch.entry_count, rsp_ch.status);
            return;
        end
        exp = pending_results.pop_front();
        if (rsp_ch.popped_value !== exp.popped) begin
            mismatch_count++;
            $display("%0t: popped_value expected %h actual %h",
                     $time, exp.popped, rsp_ch.popped_value);
        end
        if (rsp_ch.entry_count !== exp.count) begin
            mismatch_count++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, exp.count, rsp_ch.entry_count);
        end
        if (rsp_ch.status !== exp.status) begin
            mismatch_count++;
            $display("%0t: status expected %0d actual %0d",
                     $time, exp.status, rsp_ch.status);
        end
    endtask

    // ------------------------------------------------------------------------
    // Watchdog: end the run once the idle counter, cleared by any transaction on
    // either channel, reaches its limit.
    // ------------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
